// ----- hdl/alli_pkg.sv -----
// shared types and constants for the array linked list insert block
// no dependencies
`default_nettype none

package alli_pkg;

    localparam int LIST_DEPTH = 128;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int LINK_W     = $clog2(LIST_DEPTH + 1);
    localparam int COUNT_W    = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W      = ((COUNT_W > 8) ? COUNT_W : 8) + 1;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(LIST_DEPTH);

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_POS = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FREE,
        ST_WALK,
        ST_LINK,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [7:0]         position;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        status_t    status;
        logic [6:0] node_used;
        logic [7:0] list_length;
        logic       list_empty;
    } rsp_t;

    function automatic logic good_link(input logic [LINK_W-1:0] link);
        return link < NULL_LINK;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/array_linked_list_insert.sv -----
// linked list insert over a fixed node store with a free chain
// link table and value store are local synchronous memories; depends on alli_pkg
// steps: an accepted beat goes to ST_FREE, then to ST_RESULT for position 1 or an
// empty list, else via ST_WALK and ST_LINK to ST_RESULT; errors skip to ST_RESULT
// one item at a time: the walk reads one link per cycle from the link table
// throughput: next beat accepted the cycle after the result is registered
// reset: ST_INIT writes the free chain into all 128 link entries, stall held high
`default_nettype none

module array_linked_list_insert
    import alli_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    logic [LINK_W-1:0]  link_ram [LIST_DEPTH];
    logic [31:0]        value_ram [LIST_DEPTH];

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   init_cnt_reg, init_cnt_next;
    logic [LINK_W-1:0]  head_reg, head_next;
    logic [LINK_W-1:0]  free_reg, free_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         steps_reg, steps_next;
    logic [31:0]        value_reg, value_next;
    logic [IDX_W-1:0]   fresh_reg, fresh_next;
    logic [IDX_W-1:0]   prev_reg, prev_next;
    logic [LINK_W-1:0]  next_free_reg, next_free_next;
    logic               head_ins_reg, head_ins_next;
    status_t            status_reg, status_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;
    logic [LINK_W-1:0]  rd_data_reg;

    logic               link_wr;
    logic [IDX_W-1:0]   link_wr_addr;
    logic [LINK_W-1:0]  link_wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic               value_wr;

    logic               accept;
    logic               bad_pos;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   limit;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign pos_ext = CMP_W'(req.position);
    assign limit   = CMP_W'(count_reg) + CMP_W'(1);
    assign bad_pos = (req.position == 8'd0) || (pos_ext > limit);

    // link table and value store
    always_ff @(posedge clk)
    begin
        if (link_wr)
        begin
            link_ram[link_wr_addr] <= link_wr_data;
        end
        rd_data_reg <= link_ram[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (value_wr)
        begin
            value_ram[fresh_reg] <= value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_cnt_reg  <= '0;
            head_reg      <= NULL_LINK;
            free_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steps_reg     <= steps_next;
        value_reg     <= value_next;
        fresh_reg     <= fresh_next;
        prev_reg      <= prev_next;
        next_free_reg <= next_free_next;
        head_ins_reg  <= head_ins_next;
        status_reg    <= status_next;
        rsp_reg       <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        init_cnt_next  = init_cnt_reg;
        head_next      = head_reg;
        free_next      = free_reg;
        count_next     = count_reg;
        steps_next     = steps_reg;
        value_next     = value_reg;
        fresh_next     = fresh_reg;
        prev_next      = prev_reg;
        next_free_next = next_free_reg;
        head_ins_next  = head_ins_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        link_wr        = 1'b0;
        link_wr_addr   = fresh_reg;
        link_wr_data   = rd_data_reg;
        rd_addr        = fresh_reg;
        value_wr       = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                // free chain: entry i links i + 1, last entry null
                link_wr       = 1'b1;
                link_wr_addr  = init_cnt_reg;
                link_wr_data  = LINK_W'(init_cnt_reg) + LINK_W'(1);
                init_cnt_next = init_cnt_reg + IDX_W'(1);
                if (init_cnt_reg == IDX_W'(LIST_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    value_next    = req.value;
                    steps_next    = req.position - 8'd2;
                    head_ins_next = (req.position == 8'd1) || !good_link(head_reg);
                    if (bad_pos)
                    begin
                        status_next = STATUS_BAD_POS;
                        fresh_next  = '0;
                        state_next  = ST_RESULT;
                    end
                    else if (!good_link(free_reg))
                    begin
                        status_next = STATUS_FULL;
                        fresh_next  = '0;
                        state_next  = ST_RESULT;
                    end
                    else
                    begin
                        status_next = STATUS_OK;
                        fresh_next  = free_reg[IDX_W-1:0];
                        rd_addr     = free_reg[IDX_W-1:0];
                        state_next  = ST_FREE;
                    end
                end
            end
            ST_FREE:
            begin
                next_free_next = rd_data_reg;
                value_wr       = 1'b1;
                if (head_ins_reg)
                begin
                    link_wr      = 1'b1;
                    link_wr_addr = fresh_reg;
                    link_wr_data = head_reg;
                    head_next    = LINK_W'(fresh_reg);
                    state_next   = ST_RESULT;
                end
                else
                begin
                    prev_next  = head_reg[IDX_W-1:0];
                    rd_addr    = head_reg[IDX_W-1:0];
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // rd_data_reg holds the link of prev_reg
                if ((steps_reg != 8'd0) && good_link(rd_data_reg))
                begin
                    prev_next  = rd_data_reg[IDX_W-1:0];
                    rd_addr    = rd_data_reg[IDX_W-1:0];
                    steps_next = steps_reg - 8'd1;
                end
                else
                begin
                    link_wr      = 1'b1;
                    link_wr_addr = fresh_reg;
                    link_wr_data = rd_data_reg;
                    state_next   = ST_LINK;
                end
            end
            ST_LINK:
            begin
                link_wr      = 1'b1;
                link_wr_addr = prev_reg;
                link_wr_data = LINK_W'(fresh_reg);
                state_next   = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    if (status_reg == STATUS_OK)
                    begin
                        count_next = count_reg + COUNT_W'(1);
                        free_next  = next_free_reg;
                    end
                    rsp_next.status      = status_reg;
                    rsp_next.node_used   = 7'(fresh_reg);
                    rsp_next.list_length = 8'(count_next);
                    rsp_next.list_empty  = (count_next == '0);
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// self-checking bench for array_linked_list_insert: directed and random insert beats,
// predicted against a behavioral copy of the node store, link chain and free chain
// depends on alli_pkg and the block's rtl
`timescale 1ns / 1ps

module testbench;
    import alli_pkg::*;

    localparam int RANDOM_ITEMS = 1880;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = LIST_DEPTH + 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_PCT     = 32;
    localparam int REPORT_CAP   = 40;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_stall = 1'b0;
    req_t req       = '0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          calm        = 1'b0;
    bit          hold_wanted = 1'b0;

    array_linked_list_insert dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        error_count++;
        if (error_count <= REPORT_CAP)
            $display("mismatch at cycle %0d: %s got %0d want %0d",
                     cycle_count, what, got, want);
    endtask

    class insert_board;
        logic [LINK_W-1:0] link_of [LIST_DEPTH];
        logic [31:0]       value_of [LIST_DEPTH];
        logic [LINK_W-1:0] head_idx;
        logic [LINK_W-1:0] free_idx;
        int unsigned       count;
        rsp_t              expected_q [$];
        int unsigned       n_ok, n_bad, n_full;

        function new();
            for (int i = 0; i < LIST_DEPTH; i++)
            begin
                link_of[i]  = LINK_W'(i + 1);
                value_of[i] = '0;
            end
            head_idx = NULL_LINK;
            free_idx = '0;
            count    = 0;
            n_ok     = 0;
            n_bad    = 0;
            n_full   = 0;
        endfunction

        function void note_request(req_t item);
            rsp_t              want;
            logic [LINK_W-1:0] fresh;
            logic [LINK_W-1:0] prev;
            int unsigned       pos;
            int unsigned       steps;
            pos            = item.position;
            want           = '0;
            want.status    = STATUS_OK;
            if (pos < 1 || pos > count + 1)
            begin
                want.status = STATUS_BAD_POS;
                n_bad++;
            end
            else if (free_idx >= NULL_LINK)
            begin
                want.status = STATUS_FULL;
                n_full++;
            end
            else
            begin
                fresh           = free_idx;
                free_idx        = link_of[fresh];
                value_of[fresh] = item.value;
                if (pos == 1 || head_idx >= NULL_LINK)
                begin
                    link_of[fresh] = head_idx;
                    head_idx       = fresh;
                end
                else
                begin
                    prev  = head_idx;
                    steps = pos - 2;
                    while (steps > 0 && link_of[prev] < NULL_LINK)
                    begin
                        prev = link_of[prev];
                        steps--;
                    end
                    link_of[fresh] = link_of[prev];
                    link_of[prev]  = fresh;
                end
                count++;
                want.node_used = fresh[6:0];
                n_ok++;
            end
            want.list_length = count[7:0];
            want.list_empty  = (count == 0);
            expected_q.push_back(want);
        endfunction

        task check_result(rsp_t got);
            rsp_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result beat, status", got.status, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.node_used !== want.node_used)
                report_mismatch("node_used", got.node_used, want.node_used);
            if (got.list_length !== want.list_length)
                report_mismatch("list_length", got.list_length, want.list_length);
            if (got.list_empty !== want.list_empty)
                report_mismatch("list_empty", got.list_empty, want.list_empty);
        endtask

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    insert_board board = new();

    function automatic bit side_idles();
        return !calm && ($urandom_range(99) < IDLE_PCT);
    endfunction

    task automatic send_beat(input logic [7:0] position, input logic [31:0] value);
        req_t item;
        item.position = position;
        item.value    = value;
        while (side_idles())
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        board.note_request(item);
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_position();
        int unsigned r;
        int unsigned top;
        r   = $urandom_range(99);
        top = board.count + 1;
        if (board.count < LIST_DEPTH)
        begin
            if (r < 60)
                return 8'($urandom_range(top, 1));
            if (r < 70)
                return ($urandom_range(1) == 0) ? 8'd0 : 8'(top + 1);
            return 8'($urandom_range(255));
        end
        if (r < 50)
            return 8'($urandom_range(top, 1));
        if (r < 60)
            return 8'(top + 1);
        return 8'($urandom_range(255));
    endfunction

    // result side: random stall, plus one long hold-off on request
    always @(negedge clk)
    begin
        int unsigned hold_left;
        if (hold_wanted)
        begin
            hold_wanted = 1'b0;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
        end
        else
            rsp_stall <= side_idles();
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_result(rsp);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty list edges, head, tail and middle inserts, value extremes
        send_beat(8'd0,   32'h0000_0000);
        send_beat(8'd2,   32'h1234_5678);
        send_beat(8'd255, 32'hFFFF_FFFF);
        send_beat(8'd1,   32'h7FFF_FFFF);
        send_beat(8'd2,   32'h8000_0000);
        send_beat(8'd1,   32'h0000_0000);
        send_beat(8'd4,   32'hFFFF_FFFF);
        send_beat(8'd2,   32'hA5A5_A5A5);
        send_beat(8'd3,   32'h5A5A_5A5A);
        send_beat(8'd8,   32'h0000_0001);
        send_beat(8'd7,   32'hFFFF_FFFE);
        send_beat(8'd128, 32'h0F0F_0F0F);
        send_beat(8'd129, 32'hF0F0_F0F0);
        send_beat(8'd0,   32'hFFFF_FFFF);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= 700 && n < 1000);
            if (n == 300)
                hold_wanted = 1'b1;
            send_beat(pick_position(), $urandom);
        end
        calm      = 1'b0;
        req_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d inserts, %0d bad positions, %0d full-store refusals",
                 board.n_ok, board.n_bad, board.n_full);
        $display("final list length %0d, mismatches %0d", board.count, error_count);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/alli_pkg.sv
hdl/array_linked_list_insert.sv
test/testbench.sv
